// ----- design/lvc_pkg.sv -----
// lvc_pkg: shared types, constants and helper functions for the line viewport clipper
// depends on nothing; used by every module of the clipper
package lvc_pkg;

  localparam int CoordBits    = 16;
  localparam int WorkBits     = CoordBits + 2;
  localparam int MaxClipSteps = 4;
  localparam int OutBits      = 13;
  localparam int CfgBits      = 13;
  localparam int CfgIdxBits   = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    REG_VIEW_LEFT   = 2'd0,
    REG_VIEW_TOP    = 2'd1,
    REG_VIEW_WIDTH  = 2'd2,
    REG_VIEW_HEIGHT = 2'd3
  } cfg_reg_t;

  // outcode bits
  localparam logic [3:0] OC_LEFT   = 4'h1;
  localparam logic [3:0] OC_RIGHT  = 4'h2;
  localparam logic [3:0] OC_BOTTOM = 4'h4;
  localparam logic [3:0] OC_TOP    = 4'h8;

  typedef logic signed [WorkBits-1:0] coord_t;
  typedef logic [CoordBits-1:0]       mag_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } bounds_t;

  // segment as it moves through the clip passes
  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    logic   done;
    logic   ok;
  } seg_t;

  // one clip pass in flight: rem/lq hold the operands, then the product,
  // then the partial remainder and the quotient bits while dividing
  typedef struct packed {
    seg_t   seg;
    logic   lr;
    coord_t edge_pos;
    logic   neg;
    mag_t   den;
    mag_t   rem;
    mag_t   lq;
  } pass_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic [OutBits-1:0] clipped_start_x;
    logic [OutBits-1:0] clipped_start_y;
    logic [OutBits-1:0] clipped_end_x;
    logic [OutBits-1:0] clipped_end_y;
  } out_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, bounds_t bd);
    logic [3:0] c;
    c = 4'h0;
    if (x < bd.left) c = c | OC_LEFT;
    else if (x > bd.right) c = c | OC_RIGHT;
    if (y < bd.top) c = c | OC_TOP;
    else if (y > bd.bottom) c = c | OC_BOTTOM;
    return c;
  endfunction

  function automatic mag_t magnitude(coord_t v);
    coord_t a;
    a = (v < 0) ? -v : v;
    return a[CoordBits-1:0];
  endfunction

endpackage

// ----- design/lvc_cfg.sv -----
// lvc_cfg: viewport registers and the derived clip rectangle
// depends on lvc_pkg
module lvc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lvc_pkg::CfgIdxBits-1:0]    cfg_index,
  input  logic [lvc_pkg::CfgBits-1:0]       cfg_data,
  output lvc_pkg::bounds_t                  bounds
);

  logic [11:0] view_left;
  logic [11:0] view_top;
  logic [12:0] view_width;
  logic [12:0] view_height;
  logic [12:0] width_c;
  logic [12:0] height_c;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      view_left   <= 12'd0;
      view_top    <= 12'd0;
      view_width  <= 13'd320;
      view_height <= 13'd240;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lvc_pkg::REG_VIEW_LEFT:   view_left   <= cfg_data[11:0];
        lvc_pkg::REG_VIEW_TOP:    view_top    <= cfg_data[11:0];
        lvc_pkg::REG_VIEW_WIDTH:  view_width  <= cfg_data;
        lvc_pkg::REG_VIEW_HEIGHT: view_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero size counts as one, oversize as 4096
  always_comb begin
    width_c = view_width;
    if (view_width == 13'd0) width_c = 13'd1;
    else if (view_width > 13'd4096) width_c = 13'd4096;
    height_c = view_height;
    if (view_height == 13'd0) height_c = 13'd1;
    else if (view_height > 13'd4096) height_c = 13'd4096;
  end

  // rectangle edges, inclusive
  always_comb begin
    bounds.left   = lvc_pkg::coord_t'({{(lvc_pkg::WorkBits-12){1'b0}}, view_left});
    bounds.top    = lvc_pkg::coord_t'({{(lvc_pkg::WorkBits-12){1'b0}}, view_top});
    bounds.right  = bounds.left
                  + lvc_pkg::coord_t'({{(lvc_pkg::WorkBits-13){1'b0}}, width_c})
                  - lvc_pkg::coord_t'(1);
    bounds.bottom = bounds.top
                  + lvc_pkg::coord_t'({{(lvc_pkg::WorkBits-13){1'b0}}, height_c})
                  - lvc_pkg::coord_t'(1);
  end

endmodule

// ----- design/lvc_div.sv -----
// lvc_div: pipelined restoring divider, one quotient bit per stage
// depends on lvc_pkg; the pass record rides along with the operands
module lvc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_vld,
  input  lvc_pkg::pass_t  in_job,
  output logic            out_vld,
  output lvc_pkg::pass_t  out_job
);

  localparam int N = lvc_pkg::CoordBits;

  lvc_pkg::pass_t stg  [N];
  lvc_pkg::pass_t src  [N];
  lvc_pkg::pass_t nxt  [N];
  logic [N-1:0]   vld;

  // one remainder step per stage
  always_comb begin
    logic [N:0] trial;
    logic [N:0] diff;
    logic       qbit;
    for (int k = 0; k < N; k++) begin
      src[k] = (k == 0) ? in_job : stg[(k == 0) ? 0 : k - 1];
      nxt[k] = src[k];
      trial  = {src[k].rem, src[k].lq[N-1]};
      diff   = trial - {1'b0, src[k].den};
      qbit   = (trial >= {1'b0, src[k].den});
      nxt[k].rem = qbit ? diff[N-1:0] : trial[N-1:0];
      nxt[k].lq  = {src[k].lq[N-2:0], qbit};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) stg[k] <= nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N-2:0], in_vld};
    end
  end

  assign out_vld = vld[N-1];
  assign out_job = stg[N-1];

endmodule

// ----- design/lvc_pass.sv -----
// lvc_pass: one clip pass: outcode test, exchange, edge setup, product,
// divide and endpoint move; depends on lvc_pkg and lvc_div
module lvc_pass (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  lvc_pkg::bounds_t  bounds,
  input  logic              in_vld,
  input  lvc_pkg::seg_t     in_seg,
  output logic              out_vld,
  output lvc_pkg::seg_t     out_seg
);

  localparam int N = lvc_pkg::CoordBits;
  localparam int W = lvc_pkg::WorkBits;

  logic [3:0]       c1;
  logic [3:0]       c2;
  logic [3:0]       cm;
  lvc_pkg::seg_t    sw;
  lvc_pkg::coord_t  dx;
  lvc_pkg::coord_t  dy;
  lvc_pkg::coord_t  tv;
  lvc_pkg::coord_t  num;
  lvc_pkg::coord_t  den;
  lvc_pkg::pass_t   p0_next;
  lvc_pkg::pass_t   p0;
  lvc_pkg::pass_t   p1_next;
  lvc_pkg::pass_t   p1;
  lvc_pkg::pass_t   pd;
  lvc_pkg::seg_t    seg_next;
  lvc_pkg::coord_t  delta;
  logic             v0;
  logic             v1;
  logic             vd;
  logic             vo;
  logic [2*N-1:0]   prod;

  assign c1 = lvc_pkg::outcode(in_seg.x1, in_seg.y1, bounds);
  assign c2 = lvc_pkg::outcode(in_seg.x2, in_seg.y2, bounds);

  // trivial accept / reject, exchange and edge selection
  always_comb begin
    sw = in_seg;
    cm = c1;
    if (!in_seg.done) begin
      if ((c1 | c2) == 4'h0) begin
        sw.done = 1'b1;
        sw.ok   = 1'b1;
      end else if ((c1 & c2) != 4'h0) begin
        sw.done = 1'b1;
        sw.ok   = 1'b0;
      end else if (c1 == 4'h0) begin
        sw.x1 = in_seg.x2;
        sw.y1 = in_seg.y2;
        sw.x2 = in_seg.x1;
        sw.y2 = in_seg.y1;
        cm    = c2;
      end
    end
    dx = sw.x2 - sw.x1;
    dy = sw.y2 - sw.y1;
    p0_next.seg = sw;
    p0_next.lr  = ((cm & (lvc_pkg::OC_LEFT | lvc_pkg::OC_RIGHT)) != 4'h0);
    if (p0_next.lr) begin
      p0_next.edge_pos = ((cm & lvc_pkg::OC_LEFT) != 4'h0) ? bounds.left : bounds.right;
      tv  = p0_next.edge_pos - sw.x1;
      num = dy;
      den = dx;
    end else begin
      p0_next.edge_pos = ((cm & lvc_pkg::OC_BOTTOM) != 4'h0) ? bounds.bottom : bounds.top;
      tv  = p0_next.edge_pos - sw.y1;
      num = dx;
      den = dy;
    end
    p0_next.neg = tv[W-1] ^ num[W-1] ^ den[W-1];
    p0_next.den = lvc_pkg::magnitude(den);
    p0_next.rem = lvc_pkg::magnitude(tv);
    p0_next.lq  = lvc_pkg::magnitude(num);
  end

  // distance times slope numerator, fed to the divider as the dividend
  always_comb begin
    prod    = p0.rem * p0.lq;
    p1_next = p0;
    p1_next.rem = prod[2*N-1:N];
    p1_next.lq  = prod[N-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0 <= p0_next;
      p1 <= p1_next;
    end
  end

  lvc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (v1),
    .in_job  (p1),
    .out_vld (vd),
    .out_job (pd)
  );

  // move the outside end onto the chosen edge
  always_comb begin
    delta = lvc_pkg::coord_t'({{(W-N){1'b0}}, pd.lq});
    if (pd.neg) delta = -delta;
    seg_next = pd.seg;
    if (!pd.seg.done) begin
      if (pd.lr) begin
        seg_next.x1 = pd.edge_pos;
        seg_next.y1 = pd.seg.y1 + delta;
      end else begin
        seg_next.x1 = pd.seg.x1 + delta;
        seg_next.y1 = pd.edge_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_seg <= seg_next;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      vo <= 1'b0;
    end else if (adv) begin
      v0 <= in_vld;
      v1 <= v0;
      vo <= vd;
    end
  end

  assign out_vld = vo;

endmodule

// ----- design/line_viewport_clipper_unit.sv -----
// line_viewport_clipper_unit: top level of the outcode line clipper
// depends on lvc_pkg, lvc_cfg and lvc_pass
//
// Clips one line segment per transaction to the viewport rectangle.
// Input channel in_valid/in_ready carries both endpoints as signed
// coordinates; output channel out_valid/out_ready carries the accept flag
// and the clipped endpoints (all zero when rejected, ends exchanged when
// the first end started inside).
// The work runs as four clip passes in a row plus a final outcode test.
// Each pass is outcode test, one multiply stage, a 16-stage restoring
// divider and an endpoint move: 19 stages; the final outcode test feeds
// the output register.
// Throughput is one transaction per cycle; the whole pipeline advances
// together, so a stalled receiver holds every stage and in_ready follows
// out_ready whenever a result is waiting.
// The viewport registers are written on cfg_we with cfg_index choosing
// left, top, width or height; write them only while the pipeline is empty.
// Reset empties the pipeline and loads a 320 by 240 viewport at the origin.
module line_viewport_clipper_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lvc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lvc_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [lvc_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [lvc_pkg::CfgBits-1:0]     cfg_data
);

  localparam int P = lvc_pkg::MaxClipSteps;

  logic              adv;
  lvc_pkg::bounds_t  bounds;
  lvc_pkg::seg_t     chain [P+1];
  logic [P:0]        chain_vld;
  lvc_pkg::seg_t     last;
  logic [3:0]        fc1;
  logic [3:0]        fc2;
  logic              fin_ok;
  lvc_pkg::out_t     out_next;

  // whole pipeline moves unless a result is held
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  lvc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bounds    (bounds)
  );

  // widen the incoming transaction
  always_comb begin
    chain[0].x1   = lvc_pkg::coord_t'(in_data.start_x);
    chain[0].y1   = lvc_pkg::coord_t'(in_data.start_y);
    chain[0].x2   = lvc_pkg::coord_t'(in_data.end_x);
    chain[0].y2   = lvc_pkg::coord_t'(in_data.end_y);
    chain[0].done = 1'b0;
    chain[0].ok   = 1'b0;
  end
  assign chain_vld[0] = in_valid && in_ready;

  for (genvar i = 0; i < P; i++) begin : g_pass
    lvc_pass u_pass (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .bounds  (bounds),
      .in_vld  (chain_vld[i]),
      .in_seg  (chain[i]),
      .out_vld (chain_vld[i+1]),
      .out_seg (chain[i+1])
    );
  end

  // final outcode test after the last move
  assign last   = chain[P];
  assign fc1    = lvc_pkg::outcode(last.x1, last.y1, bounds);
  assign fc2    = lvc_pkg::outcode(last.x2, last.y2, bounds);
  assign fin_ok = last.done ? last.ok : ((fc1 | fc2) == 4'h0);

  always_comb begin
    out_next.accepted        = fin_ok;
    out_next.clipped_start_x = fin_ok ? last.x1[lvc_pkg::OutBits-1:0] : '0;
    out_next.clipped_start_y = fin_ok ? last.y1[lvc_pkg::OutBits-1:0] : '0;
    out_next.clipped_end_x   = fin_ok ? last.x2[lvc_pkg::OutBits-1:0] : '0;
    out_next.clipped_end_y   = fin_ok ? last.y2[lvc_pkg::OutBits-1:0] : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) out_data <= out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= chain_vld[P];
    end
  end

endmodule
